### src/lrc_pkg.sv
// Shared types and constants for the 3x3 local rank contrast block.
// Holds the sequencer state type, register indexes, window tap tables and the
// rank scaling table. No dependencies.
`default_nettype none

package lrc_pkg;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
	localparam logic [8:0]  WIDTH_RESET  = 9'd256;
	localparam logic [12:0] HEIGHT_RESET = 13'd256;

	// Frame geometry limits that do not vary.
	localparam int MAX_HEIGHT = 4096;
	localparam int ROW_W      = 12;

	// Input item kinds carried on tuser.
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_TAIL,
		ST_EMIT
	} state_t;

	// Window sweep: step 0 fetches the center, steps 1 to 8 the neighbors.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] CENTER_STEP = 4'd0;
	localparam logic [STEP_W-1:0] LAST_STEP   = 4'd8;

	// Row and column offset codes of a tap.
	localparam logic [1:0] OFS_NEG  = 2'd0;
	localparam logic [1:0] OFS_SAME = 2'd1;
	localparam logic [1:0] OFS_POS  = 2'd2;

	localparam logic [1:0] NB_ROW [9] = '{
		OFS_SAME, OFS_NEG, OFS_NEG, OFS_NEG, OFS_SAME,
		OFS_SAME, OFS_POS, OFS_POS, OFS_POS
	};
	localparam logic [1:0] NB_COL [9] = '{
		OFS_SAME, OFS_NEG, OFS_SAME, OFS_POS, OFS_NEG,
		OFS_POS, OFS_NEG, OFS_SAME, OFS_POS
	};

	// floor(count * 256 / area), indexed by area then count.
	localparam logic [7:0] RANK_LUT [10][9] = '{
		'{8'd0, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
		'{8'd0, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
		'{8'd0, 8'd128, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
		'{8'd0, 8'd85,  8'd170, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
		'{8'd0, 8'd64,  8'd128, 8'd192, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
		'{8'd0, 8'd51,  8'd102, 8'd153, 8'd204, 8'd0,   8'd0,   8'd0,   8'd0},
		'{8'd0, 8'd42,  8'd85,  8'd128, 8'd170, 8'd213, 8'd0,   8'd0,   8'd0},
		'{8'd0, 8'd36,  8'd73,  8'd109, 8'd146, 8'd182, 8'd219, 8'd0,   8'd0},
		'{8'd0, 8'd32,  8'd64,  8'd96,  8'd128, 8'd160, 8'd192, 8'd224, 8'd0},
		'{8'd0, 8'd28,  8'd56,  8'd85,  8'd113, 8'd142, 8'd170, 8'd199, 8'd227}
	};

endpackage

`default_nettype wire

### src/local_rank_contrast_3x3.sv
// Top level of the 3x3 local rank contrast block: pixel history, window sweep
// and result register. Depends on lrc_pkg and lrc_ram.
//
// The input is held off from the item that completes a window until its result
// is loaded: the sequencer sweeps the nine window taps through the single read
// port of the history RAM in READ, then passes TAIL and EMIT, which waits for
// the output register. An item that releases no result does not hold it off.
// Reset clears positions and sequencer and sets width and height to 256; the
// history RAM is not cleared, and taps outside the image are not counted.
`default_nettype none

module local_rank_contrast_3x3 #(
	parameter int MAX_WIDTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel_in
	input  logic                           s_axis_tuser,   // [0] mode
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,   // [7:0] rank_value
	output logic                           m_axis_tlast
);

	localparam int DEPTH = 2 * MAX_WIDTH + 3;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int GW    = $clog2(MAX_WIDTH + 3);
	localparam int SW    = AW + 2;

	// Configuration and geometry.
	logic [8:0]  width_q;
	logic [12:0] height_q;
	logic [WW-1:0] w_eff;
	logic [12:0]   h_eff;

	// Stream position state. gap_q is the count of arrived pixels beyond the
	// center of the next result.
	logic [AW-1:0]           wr_ptr_q;
	logic [GW-1:0]           gap_q;
	logic [CW-1:0]           col_q;
	logic [lrc_pkg::ROW_W-1:0] row_q;

	lrc_pkg::state_t state_q, state_d;
	logic [lrc_pkg::STEP_W-1:0] step_q, step_d;

	// Window context latched when a result is released.
	logic [AW-1:0] center_q;
	logic top_q, bottom_q, left_q, right_q, last_q;
	logic [3:0] area_q;
	logic [3:0] count_q;
	logic [7:0] cval_q;

	logic                       rd_valid_s1;
	logic [lrc_pkg::STEP_W-1:0] rd_step_s1;
	logic [7:0]                 rdata;

	logic out_valid_q, out_last_q;
	logic [7:0] out_data_q;

	// Accept-time logic.
	logic acc_in, pix, ready_now, col_last, row_last, load_out;
	logic top, bottom, left, right;
	logic [GW-1:0] gap_nx;
	logic [AW-1:0] wr_inc, wr_nx, ctr_addr;
	logic [AW:0]   ctr_sum;
	logic [WW:0]   dneed;
	logic [1:0]    rows, cols;

	// Tap address and in-image check.
	logic [1:0]    nb_row, nb_col, s1_row, s1_col;
	logic [SW-1:0] row_term, nb_sum;
	logic [AW-1:0] rd_addr;
	logic          s1_in_image;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = 13'd1;
		end else if (32'(height_q) > lrc_pkg::MAX_HEIGHT) begin
			h_eff = 13'(lrc_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign s_axis_tready = (state_q == lrc_pkg::ST_IDLE);
	assign acc_in        = s_axis_tvalid && s_axis_tready;
	assign pix           = (s_axis_tuser == lrc_pkg::MODE_PIXEL);

	always_comb begin
		gap_nx   = gap_q + GW'(pix);
		wr_inc   = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
		wr_nx    = pix ? wr_inc : wr_ptr_q;
		col_last = (WW'(col_q) == w_eff - WW'(1));
		row_last = (13'(row_q) == h_eff - 13'd1);
		top      = (row_q != '0);
		bottom   = !row_last;
		left     = (col_q != '0);
		right    = !col_last;
		// The window is complete once the pixel right of the row below is in.
		dneed     = (bottom ? {1'b0, w_eff} : '0) + (WW + 1)'(right);
		ready_now = (32'(gap_nx) > 32'(dneed));
		ctr_sum   = {1'b0, wr_nx} + (AW + 1)'(DEPTH) - (AW + 1)'(gap_nx);
		ctr_addr  = (ctr_sum >= (AW + 1)'(DEPTH)) ? AW'(ctr_sum - (AW + 1)'(DEPTH))
		                                           : AW'(ctr_sum);
		rows = 2'd1 + 2'(top) + 2'(bottom);
		cols = 2'd1 + 2'(left) + 2'(right);
	end

	// History address of the current tap: center plus row and column offset,
	// taken modulo the history depth.
	always_comb begin
		nb_row = lrc_pkg::NB_ROW[step_q];
		nb_col = lrc_pkg::NB_COL[step_q];
		unique case (nb_row)
			lrc_pkg::OFS_NEG:  row_term = '0;
			lrc_pkg::OFS_SAME: row_term = SW'(w_eff);
			default:           row_term = SW'(w_eff) << 1;
		endcase
		nb_sum = SW'(center_q) + SW'(DEPTH) + row_term + SW'(nb_col)
		         - SW'(w_eff) - SW'(1);
		if (nb_sum >= SW'(2 * DEPTH)) begin
			rd_addr = AW'(nb_sum - SW'(2 * DEPTH));
		end else if (nb_sum >= SW'(DEPTH)) begin
			rd_addr = AW'(nb_sum - SW'(DEPTH));
		end else begin
			rd_addr = AW'(nb_sum);
		end
	end

	always_comb begin
		s1_row      = lrc_pkg::NB_ROW[rd_step_s1];
		s1_col      = lrc_pkg::NB_COL[rd_step_s1];
		s1_in_image = (s1_row != lrc_pkg::OFS_NEG || top_q)
		           && (s1_row != lrc_pkg::OFS_POS || bottom_q)
		           && (s1_col != lrc_pkg::OFS_NEG || left_q)
		           && (s1_col != lrc_pkg::OFS_POS || right_q);
	end

	lrc_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (acc_in && pix),
		.waddr (wr_ptr_q),
		.wdata (s_axis_tdata),
		.re    (state_q == lrc_pkg::ST_READ),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign load_out = (state_q == lrc_pkg::ST_EMIT) && (!out_valid_q || m_axis_tready);

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		unique case (state_q)
			lrc_pkg::ST_IDLE: begin
				if (acc_in && ready_now) begin
					state_d = lrc_pkg::ST_READ;
					step_d  = lrc_pkg::CENTER_STEP;
				end
			end
			lrc_pkg::ST_READ: begin
				if (step_q == lrc_pkg::LAST_STEP) begin
					state_d = lrc_pkg::ST_TAIL;
				end else begin
					step_d = step_q + lrc_pkg::STEP_W'(1);
				end
			end
			lrc_pkg::ST_TAIL: begin
				state_d = lrc_pkg::ST_EMIT;
			end
			lrc_pkg::ST_EMIT: begin
				if (load_out) begin
					state_d = lrc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lrc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrc_pkg::ST_IDLE;
			step_q  <= lrc_pkg::CENTER_STEP;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// Configuration, positions and pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lrc_pkg::WIDTH_RESET;
			height_q <= lrc_pkg::HEIGHT_RESET;
			wr_ptr_q <= '0;
			gap_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (acc_in) begin
				wr_ptr_q <= wr_nx;
				gap_q    <= gap_nx - GW'(ready_now);
				if (ready_now) begin
					if (col_last) begin
						col_q <= '0;
						row_q <= row_last ? '0 : row_q + lrc_pkg::ROW_W'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
			end
			// A register write restarts the frame; the history is kept.
			if (cfg_we) begin
				unique case (cfg_index)
					lrc_pkg::REG_WIDTH:  width_q  <= cfg_wdata[8:0];
					lrc_pkg::REG_HEIGHT: height_q <= cfg_wdata;
					default: ;
				endcase
				gap_q <= '0;
				col_q <= '0;
				row_q <= '0;
			end
		end
	end

	// Window sweep bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			rd_step_s1  <= lrc_pkg::CENTER_STEP;
			count_q     <= '0;
		end else begin
			rd_valid_s1 <= (state_q == lrc_pkg::ST_READ);
			rd_step_s1  <= step_q;
			if (acc_in) begin
				count_q <= '0;
			end else if (rd_valid_s1 && rd_step_s1 != lrc_pkg::CENTER_STEP
			             && s1_in_image && rdata < cval_q) begin
				count_q <= count_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && ready_now) begin
			center_q <= ctr_addr;
			top_q    <= top;
			bottom_q <= bottom;
			left_q   <= left;
			right_q  <= right;
			last_q   <= row_last && col_last;
			area_q   <= 4'(rows) * 4'(cols);
		end
		if (rd_valid_s1 && rd_step_s1 == lrc_pkg::CENTER_STEP) begin
			cval_q <= rdata;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= lrc_pkg::RANK_LUT[area_q][count_q];
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// A drain item never widens the lead of the input over the output.
	a_drain_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && !pix) |=> (gap_q <= $past(gap_q)))
		else $error("drain item increased the pixel lead");

	a_start_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && ready_now) |=>
		(state_q == lrc_pkg::ST_READ && step_q == lrc_pkg::CENTER_STEP))
		else $error("released result did not start the window sweep");

	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == lrc_pkg::ST_EMIT))
		else $error("result register loaded outside the emit step");

	// The center is never darker than itself, so the count stays below the area.
	a_count_area: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lrc_pkg::ST_EMIT) |-> (count_q < area_q))
		else $error("darker count reached the window area");

endmodule

`default_nettype wire

### src/lrc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
`default_nettype none

module lrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 515
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
